### src/bhq_pkg.sv
// Package with shared types, constants and codes for the binary max heap queue.
package bhq_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 256;
    localparam int STATUS_W     = 2;

    localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] data;
    } slot_t;

    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

endpackage

### src/bhq_if.sv
// Valid/ready channel interfaces for the queue's input and result transactions.
interface bhq_in_if
    import bhq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface bhq_out_if
    import bhq_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [DATA_W-1:0]   root_value;
    logic        [STATUS_W-1:0] status;
    logic                       now_empty;

    modport source (output valid, output root_value, output status, output now_empty,
                    input ready);
    modport sink   (input valid, input root_value, input status, input now_empty,
                    output ready);
endinterface

### src/binary_max_heap_queue_top.sv
// Top level of the max priority queue: a sorted row of cells with a registered result.
//
// The queue keeps its elements in a row of CAPACITY cells sorted from largest to
// smallest, so the maximum always sits in the first cell. Every cell compares a
// new element with its own in parallel; an insert shifts the smaller elements one
// cell down the row and a delete shifts the whole row one cell up. One
// transaction is accepted per cycle, and its result is offered the cycle after
// acceptance from an output register; the input stays ready while that register
// is empty or being drained. A delete on an empty queue returns the most
// negative value with an underflow status, and an insert into a full queue is
// dropped with an overflow status. No clearing pass is run after reset.
module binary_max_heap_queue_top
    import bhq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    bhq_in_if.sink           in_ch,
    bhq_out_if.source        out_ch
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic signed [DATA_W-1:0]   root_value_reg;
    logic signed [DATA_W-1:0]   root_value_next;
    logic        [STATUS_W-1:0] status_reg;
    logic        [STATUS_W-1:0] status_next;
    logic                       now_empty_reg;
    logic                       now_empty_next;

    logic  accept;
    logic  is_empty;
    logic  is_full;
    cmd_t  cmd;
    slot_t slots [CAPACITY];
    logic  disps [CAPACITY];

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign is_empty    = (count_reg == '0);
    assign is_full     = (count_reg == CNT_W'(CAPACITY));

    assign cmd.ins   = accept && (in_ch.action == ACT_INSERT) && !is_full;
    assign cmd.del   = accept && (in_ch.action == ACT_DELETE) && !is_empty;
    assign cmd.value = in_ch.value;

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            slot_t prev_slot;
            logic  prev_disp;
            slot_t next_slot;

            if (i == 0)
            begin : g_first
                assign prev_slot = '{valid: 1'b0, data: '0};
                assign prev_disp = 1'b0;
            end
            else
            begin : g_mid
                assign prev_slot = slots[i-1];
                assign prev_disp = disps[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign next_slot = '{valid: 1'b0, data: '0};
            end
            else
            begin : g_inner
                assign next_slot = slots[i+1];
            end

            bhq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .prev_slot (prev_slot),
                .prev_disp (prev_disp),
                .next_slot (next_slot),
                .slot      (slots[i]),
                .disp      (disps[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        root_value_next = root_value_reg;
        status_next     = status_reg;
        now_empty_next  = now_empty_reg;
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next  = 1'b1;
            root_value_next = '0;
            status_next     = ST_OK;
            if (in_ch.action == ACT_INSERT)
            begin
                if (is_full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (is_empty)
                begin
                    root_value_next = INT_MIN;
                    status_next     = ST_UNDERFLOW;
                end
                else
                begin
                    root_value_next = slots[0].data;
                    count_next      = count_reg - CNT_W'(1);
                end
            end
            now_empty_next = (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        root_value_reg <= root_value_next;
        status_reg     <= status_next;
        now_empty_reg  <= now_empty_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.root_value = root_value_reg;
    assign out_ch.status     = status_reg;
    assign out_ch.now_empty  = now_empty_reg;

endmodule

### src/bhq_cell.sv
// One cell of the sorted row: holds a single element and trades it with its neighbors.
module bhq_cell
    import bhq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  slot_t prev_slot,
    input  logic  prev_disp,
    input  slot_t next_slot,
    output slot_t slot,
    output logic  disp
);

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    // The cell gives way to a new element when it is empty or holds a smaller one.
    assign disp = !valid_reg || (cmd.value > data_reg);
    assign slot = '{valid: valid_reg, data: data_reg};

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (cmd.ins && disp)
        begin
            if (prev_disp)
            begin
                valid_next = prev_slot.valid;
                data_next  = prev_slot.data;
            end
            else
            begin
                valid_next = 1'b1;
                data_next  = cmd.value;
            end
        end
        else if (cmd.del)
        begin
            valid_next = next_slot.valid;
            data_next  = next_slot.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
